/* hdl/stlb_pkg.sv */
// Shared types and constants for the sorted table lower-bound search block.
// No dependencies; every other file of the block refers to this package by scoped names.
package stlb_pkg;

    // Default table depth and queue depth for the top-level parameters.
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Fixed field widths of the item formats.
    localparam int SLOT_W  = 10;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 11;
    localparam int POS_W   = 11;

    // Request type codes as they arrive on the input port.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Command kinds after classification by the front end.
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_kind_t;

    // Input beat.
    typedef struct packed {
        logic                      req_type;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic                      found;
        logic signed [VALUE_W-1:0] value_at_position;
    } rsp_t;

    // Classified command passed from the front end to the search engine.
    typedef struct packed {
        cmd_kind_t                 kind;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    // Occupancy status of the command queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

/* hdl/stlb_front.sv */
// Front end: accepts input beats, holds the element count register and classifies items.
// Depends on stlb_pkg.
module stlb_front #(
    parameter int TABLE_DEPTH = stlb_pkg::TABLE_DEPTH_DEF,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  stlb_pkg::req_t              req,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [stlb_pkg::COUNT_W-1:0] cfg_data,
    output logic [CNT_W-1:0]            count_sat,
    output logic                        cmd_valid,
    output stlb_pkg::cmd_t              cmd,
    input  logic                        cmd_ready
);

    logic [stlb_pkg::COUNT_W-1:0] element_count_reg;
    logic                         cmd_valid_reg;
    logic                         cmd_valid_next;
    stlb_pkg::cmd_t               cmd_reg;
    logic                         accept;
    logic                         keep;

    // The configuration register can always be written.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            element_count_reg <= cfg_data;
        end
    end

    // Counts above the table depth saturate to the depth.
    assign count_sat = (32'(element_count_reg) > 32'(TABLE_DEPTH)) ?
                       CNT_W'(TABLE_DEPTH) : CNT_W'(element_count_reg);

    // A beat is taken when the stage is empty or drains in this cycle.
    assign full   = cmd_valid_reg && !cmd_ready;
    assign accept = push && !full;

    // Loads that land beyond the table are dropped here; queries always pass.
    assign keep = (req.req_type == stlb_pkg::REQ_QUERY) ||
                  (32'(req.slot) < 32'(TABLE_DEPTH));

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd_valid_reg && cmd_ready)
        begin
            cmd_valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            cmd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // Command payload, classified from the request type.
    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            cmd_reg.kind  <= (req.req_type == stlb_pkg::REQ_QUERY) ?
                             stlb_pkg::CMD_QUERY : stlb_pkg::CMD_LOAD;
            cmd_reg.slot  <= req.slot;
            cmd_reg.value <= req.value;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

/* hdl/stlb_queue.sv */
// Short command queue that decouples the front end from the search engine.
// Depends on stlb_pkg.
module stlb_queue #(
    parameter int DEPTH = stlb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  stlb_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output stlb_pkg::cmd_t       head_cmd,
    output stlb_pkg::queue_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    stlb_pkg::cmd_t   entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             wr_en;
    logic             rd_en;

    assign stat.full  = (occ_reg == OCC_W'(DEPTH));
    assign stat.empty = (occ_reg == '0);
    assign wr_en      = push && !stat.full;
    assign rd_en      = pop && !stat.empty;

    // Pointer and occupancy update with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd = entries_reg[rd_ptr_reg];

endmodule

/* hdl/stlb_back.sv */
// Search engine: holds the entry memory, runs the bisection and owns the result register.
// Depends on stlb_pkg.
module stlb_back #(
    parameter int TABLE_DEPTH = stlb_pkg::TABLE_DEPTH_DEF,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stlb_pkg::queue_stat_t q_stat,
    input  stlb_pkg::cmd_t        q_cmd,
    output logic                  q_pop,
    input  logic [CNT_W-1:0]      count_sat,
    output logic                  empty,
    input  logic                  pop,
    output stlb_pkg::rsp_t        rsp
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CMP   = 5'b00100,
        S_FETCH = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic signed [stlb_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];
    logic signed [stlb_pkg::VALUE_W-1:0] rdata_reg;
    logic signed [stlb_pkg::VALUE_W-1:0] key_reg;
    logic signed [stlb_pkg::VALUE_W-1:0] key_next;
    logic [CNT_W-1:0]                    ok_reg;
    logic [CNT_W-1:0]                    ok_next;
    logic [CNT_W-1:0]                    ng_p1_reg;
    logic [CNT_W-1:0]                    ng_p1_next;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic                                hit_reg;
    logic                                hit_next;
    logic                                rsp_valid_reg;
    logic                                rsp_valid_next;
    stlb_pkg::rsp_t                      rsp_reg;
    logic [CNT_W:0]                      mid_sum;
    logic [CNT_W-1:0]                    mid;
    logic [ADDR_W-1:0]                   rd_addr;
    logic                                rd_en;
    logic                                mem_we;
    logic                                ge;
    logic                                out_free;
    logic                                rsp_load;

    // The false bound is kept as its value plus one, so it stays unsigned.
    // Midpoint of the two bounds, rounded toward minus infinity.
    assign mid_sum = {1'b0, ok_reg} + {1'b0, ng_p1_reg} - 1'b1;
    assign mid     = mid_sum[CNT_W:1];

    // Probe compare of the fetched entry against the key.
    assign ge = (rdata_reg >= key_reg);

    assign out_free = !rsp_valid_reg || pop;
    assign q_pop    = (state_reg == S_IDLE) && !q_stat.empty;
    assign mem_we   = q_pop && (q_cmd.kind == stlb_pkg::CMD_LOAD);
    assign rd_en    = (state_reg == S_READ) || (state_reg == S_FETCH);
    assign rd_addr  = (state_reg == S_FETCH) ? ADDR_W'(ok_reg) : ADDR_W'(mid);
    assign rsp_load = (state_reg == S_DONE) && out_free;

    // Bisection sequencer.
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        ok_next    = ok_reg;
        ng_p1_next = ng_p1_reg;
        count_next = count_reg;
        hit_next   = hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop && (q_cmd.kind == stlb_pkg::CMD_QUERY))
                begin
                    key_next   = q_cmd.value;
                    ok_next    = count_sat;
                    ng_p1_next = '0;
                    count_next = count_sat;
                    hit_next   = 1'b0;
                    state_next = (count_sat != '0) ? S_READ : S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (ge)
                begin
                    ok_next = mid;
                end
                else
                begin
                    ng_p1_next = mid + 1'b1;
                end
                if (ok_next != ng_p1_next)
                begin
                    state_next = S_READ;
                end
                else if (ok_next < count_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FETCH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ok_reg    <= '0;
            ng_p1_reg <= '0;
            count_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
            ng_p1_reg <= ng_p1_next;
            count_reg <= count_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    // Entry memory: one write port for loads, one registered read port for probes and the result fetch.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ADDR_W'(q_cmd.slot)] <= q_cmd.value;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Result register; a finished result waits here while the next command starts.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && pop)
        begin
            rsp_valid_next = 1'b0;
        end
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg.position          <= stlb_pkg::POS_W'(ok_reg);
            rsp_reg.found             <= hit_reg;
            rsp_reg.value_at_position <= hit_reg ? rdata_reg : '0;
        end
    end

    assign empty = !rsp_valid_reg;
    assign rsp   = rsp_reg;

endmodule

/* hdl/sorted_table_lower_bound.sv */
// Lower-bound search over a table of signed 64-bit entries, loaded one beat at a time.
// A load is written to the entry memory when the engine dequeues it. A query is dequeued,
// runs a bisection (one memory read and one compare per step), fetches the entry at the
// found position on a hit and posts the result. The engine takes a new command from the
// queue only once it is through with the previous one.
// Reset clears the count to zero and empties all queues; table contents stay undefined.
module sorted_table_lower_bound #(
    parameter int TABLE_DEPTH = stlb_pkg::TABLE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = stlb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  stlb_pkg::req_t               req,
    input  logic                         pop,
    output logic                         empty,
    output stlb_pkg::rsp_t               rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [stlb_pkg::COUNT_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic                  cmd_valid;
    stlb_pkg::cmd_t        cmd;
    stlb_pkg::cmd_t        q_cmd;
    stlb_pkg::queue_stat_t q_stat;
    logic                  q_pop;
    logic [CNT_W-1:0]      count_sat;

    // Front end: input beats, count register and classification.
    stlb_front #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .count_sat (count_sat),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (!q_stat.full)
    );

    // Command queue between the two halves.
    stlb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_valid),
        .push_cmd (cmd),
        .pop      (q_pop),
        .head_cmd (q_cmd),
        .stat     (q_stat)
    );

    // Search engine and result register.
    stlb_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .count_sat (count_sat),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

    // The front end only stalls when the queue behind it is full.
    a_full_means_queue_full: assert property (
        @(posedge clk) disable iff (!rst_n) full |-> q_stat.full
    ) else $error("front end stalled while the command queue had room");

    // The engine never dequeues from an empty queue.
    a_pop_nonempty: assert property (
        @(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty
    ) else $error("command dequeued from an empty queue");

    // A miss carries a zero value.
    a_miss_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !rsp.found) |-> (rsp.value_at_position == '0)
    ) else $error("result without a hit carries a nonzero value");

endmodule

/* tb/tb_sorted_table_lower_bound.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sorted table lower-bound search block.
// Depends on stlb_pkg and sorted_table_lower_bound; drives loads, queries and count writes
// and checks every search answer against an in-bench bisection over a copy of the table.
module tb_sorted_table_lower_bound;

    localparam int TABLE_DEPTH = stlb_pkg::TABLE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int IDLE_PERCENT = 11;
    localparam logic signed [stlb_pkg::VALUE_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [stlb_pkg::VALUE_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    stlb_pkg::req_t req = '0;
    logic pop = 1'b0;
    logic empty;
    stlb_pkg::rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [stlb_pkg::COUNT_W-1:0] cfg_data = '0;

    // Bench copy of the table and of the count register.
    logic signed [stlb_pkg::VALUE_W-1:0] entry_copy [TABLE_DEPTH];
    int used_count = 0;
    stlb_pkg::rsp_t pending_answers [$];

    // Steady traffic: neither side idles while this is set.
    bit steady = 1'b0;
    int mismatches = 0;
    int loads_sent = 0;
    int queries_sent = 0;
    int count_writes = 0;
    int quiet_cycles = 0;

    sorted_table_lower_bound u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .pop       (pop),
        .empty     (empty),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock generator: 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bisection over the bench copy of the table, as the block should run it.
    function automatic stlb_pkg::rsp_t lower_bound_of(
        input logic signed [stlb_pkg::VALUE_W-1:0] key);
        stlb_pkg::rsp_t answer;
        int span;
        int ok;
        int ng;
        int mid;
        span = (used_count > TABLE_DEPTH) ? TABLE_DEPTH : used_count;
        ok = span;
        ng = -1;
        while (ok - ng > 1)
        begin
            mid = (ok + ng) / 2;
            if (entry_copy[mid] >= key)
                ok = mid;
            else
                ng = mid;
        end
        answer.position = ok[stlb_pkg::POS_W-1:0];
        answer.found = (ok < span);
        answer.value_at_position = (ok < span) ? entry_copy[ok] : '0;
        return answer;
    endfunction

    function automatic void report_mismatch(input string field, input longint want_v,
                                            input longint got_v);
        if (mismatches < 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want_v, got_v);
        mismatches++;
    endfunction

    // Send one input beat; the sender may idle first.
    task automatic send_item(input stlb_pkg::req_t item);
        if (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (full);
        if (item.req_type == stlb_pkg::REQ_LOAD)
        begin
            entry_copy[item.slot] = item.value;
            loads_sent++;
        end
        else
        begin
            pending_answers.push_back(lower_bound_of(item.value));
            queries_sent++;
        end
    endtask

    task automatic send_load(input int slot, input logic signed [stlb_pkg::VALUE_W-1:0] v);
        stlb_pkg::req_t item;
        item.req_type = stlb_pkg::REQ_LOAD;
        item.slot = slot[stlb_pkg::SLOT_W-1:0];
        item.value = v;
        send_item(item);
    endtask

    task automatic send_query(input logic signed [stlb_pkg::VALUE_W-1:0] key);
        stlb_pkg::req_t item;
        item.req_type = stlb_pkg::REQ_QUERY;
        item.slot = stlb_pkg::SLOT_W'($urandom_range(TABLE_DEPTH - 1));
        item.value = key;
        send_item(item);
    endtask

    // Stop sending until every outstanding answer has come back.
    task automatic wait_for_answers();
        push <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() > 0)
            @(posedge clk);
    endtask

    // The count is only changed while the block is idle; loads give no answer,
    // so allow for one still in flight after the last answer.
    task automatic write_count(input int setting);
        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= setting[stlb_pkg::COUNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        used_count = setting;
        cfg_valid <= 1'b0;
        count_writes++;
    endtask

    // Search key: mostly values present in the table or next to them.
    function automatic logic signed [stlb_pkg::VALUE_W-1:0] pick_key();
        int span;
        int r;
        logic signed [stlb_pkg::VALUE_W-1:0] k;
        span = (used_count > TABLE_DEPTH) ? TABLE_DEPTH : used_count;
        r = $urandom_range(99);
        if (span > 0 && r < 40)
            k = entry_copy[$urandom_range(span - 1)];
        else if (span > 0 && r < 50)
            k = entry_copy[$urandom_range(span - 1)] + 64'sd1;
        else if (span > 0 && r < 60)
            k = entry_copy[$urandom_range(span - 1)] - 64'sd1;
        else if (r < 70)
            k = r[0] ? VAL_MAX : VAL_MIN;
        else
            k = {$urandom, $urandom};
        return k;
    endfunction

    // Load value: usually one that keeps the slot between its neighbors, sometimes noise.
    function automatic logic signed [stlb_pkg::VALUE_W-1:0] pick_load_value(input int slot);
        logic signed [stlb_pkg::VALUE_W-1:0] lo;
        logic signed [stlb_pkg::VALUE_W-1:0] hi;
        logic signed [stlb_pkg::VALUE_W-1:0] v;
        int r;
        lo = (slot == 0) ? VAL_MIN : entry_copy[slot - 1];
        hi = (slot == TABLE_DEPTH - 1) ? VAL_MAX : entry_copy[slot + 1];
        r = $urandom_range(99);
        if (r < 10 || hi < lo)
            v = {$urandom, $urandom};
        else if (r < 30)
            v = lo;
        else if (r < 50)
            v = hi;
        else
            v = (lo >>> 1) + (hi >>> 1) + (lo & hi & 64'sd1);
        return v;
    endfunction

    // Result checker: takes a beat when pop and not empty, and drives pop for the next cycle.
    initial
    begin : result_checker
        stlb_pkg::rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_answers.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result beat, position %0d", $realtime,
                                 rsp.position);
                    mismatches++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp.position !== want.position)
                        report_mismatch("position", want.position, rsp.position);
                    if (rsp.found !== want.found)
                        report_mismatch("found", want.found, rsp.found);
                    if (rsp.value_at_position !== want.value_at_position)
                        report_mismatch("value_at_position", want.value_at_position,
                                        rsp.value_at_position);
                end
            end
            pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // With no entries in use every search misses at position zero.
    task automatic test_empty_table();
        write_count(0);
        send_query(VAL_MIN);
        send_query(64'sd0);
        send_query(VAL_MAX);
    endtask

    // Sorted table with duplicates and both extremes of the value range.
    task automatic test_small_sorted_table();
        send_load(0, VAL_MIN);
        send_load(1, VAL_MIN);
        send_load(2, -64'sd1);
        send_load(3, 64'sd0);
        send_load(4, 64'sd0);
        send_load(5, 64'sd1);
        send_load(6, VAL_MAX - 64'sd1);
        send_load(7, VAL_MAX);
        write_count(8);
        send_query(VAL_MIN);
        send_query(-64'sd2);
        send_query(64'sd0);
        send_query(64'sd1);
        send_query(64'sd2);
        send_query(VAL_MAX);
        // One entry in use: a key above it misses.
        write_count(1);
        send_query(VAL_MIN + 64'sd1);
        // The largest key past the used part: position equals the count.
        write_count(7);
        send_query(VAL_MAX);
    endtask

    // An unsorted table still gives whatever boundary the bisection reaches.
    task automatic test_unsorted_table();
        send_load(0, 64'sd5);
        send_load(1, -64'sd7);
        send_load(2, 64'sd100);
        send_load(3, 64'sd3);
        write_count(4);
        send_query(64'sd4);
        send_query(64'sd50);
    endtask

    // Whole table loaded in order; counts at and beyond the depth saturate.
    task automatic test_full_table();
        longint sorted_vals [$];
        steady = 1'b1;
        sorted_vals.push_back(VAL_MIN);
        sorted_vals.push_back(VAL_MAX);
        while (sorted_vals.size() < TABLE_DEPTH)
        begin
            if ($urandom_range(99) < 10)
                sorted_vals.push_back(sorted_vals[sorted_vals.size() - 1]);
            else
                sorted_vals.push_back({$urandom, $urandom});
        end
        sorted_vals.sort();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_load(i, sorted_vals[i]);
        steady = 1'b0;
        write_count(TABLE_DEPTH);
        repeat (10) send_query(pick_key());
        write_count((1 << stlb_pkg::COUNT_W) - 1);
        repeat (10) send_query(pick_key());
        write_count(TABLE_DEPTH + 1);
        repeat (5) send_query(pick_key());
    endtask

    // Random mix of loads and searches over several count settings.
    task automatic test_random_traffic();
        int settings [10];
        int slot;
        settings = '{1, 2, TABLE_DEPTH, 5, (1 << stlb_pkg::COUNT_W) - 1, 0, 37,
                     $urandom_range(1, TABLE_DEPTH), TABLE_DEPTH + 1, 513};
        for (int p = 0; p < 10; p++)
        begin
            write_count(settings[p]);
            steady = (p == 4);
            for (int i = 0; i < 6; i++)
            begin
                // Hold the sender off once until the block has drained.
                if (p == 2 && i == 3)
                    wait_for_answers();
                if ($urandom_range(99) < 30)
                begin
                    slot = $urandom_range(TABLE_DEPTH - 1);
                    send_load(slot, pick_load_value(slot));
                end
                else
                    send_query(pick_key());
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_small_sorted_table();
        test_unsorted_table();
        test_full_table();
        test_random_traffic();
        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Searched %0d keys and loaded %0d entries under %0d count settings,",
                 queries_sent, loads_sent, count_writes);
        $display("including empty, single-entry, full and saturated counts; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
hdl/stlb_pkg.sv
hdl/stlb_front.sv
hdl/stlb_queue.sv
hdl/stlb_back.sv
hdl/sorted_table_lower_bound.sv
tb/tb_sorted_table_lower_bound.sv
